FILE: hw/rtl/tmps_pkg.sv
`timescale 1ns / 1ps

package tmps_pkg;

    // fixed field widths
    localparam int ENTRY_W    = 16;
    localparam int OUT_W      = 22;
    localparam int OUT_BYTES_W = 24;
    localparam int NUM_ROWS_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // register index
    localparam logic [APB_ADDR_W-1:0] REG_NUM_ROWS = 2'd0;

    // output saturation limits
    localparam int OUT_MAX_I = (2 ** (OUT_W - 1)) - 1;
    localparam int OUT_MIN_I = -(2 ** (OUT_W - 1));

    // per-entry position flags carried into the update stage
    typedef struct packed {
        logic top_row;
        logic first_col;
        logic last_col;
        logic last_row;
        logic tri_end;
    } t_s1_ctl;

endpackage

FILE: hw/rtl/tmps_ram.sv
`timescale 1ns / 1ps

module tmps_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/triangle_max_path_sum_top.sv
`timescale 1ns / 1ps

// Number triangle maximum path sum. Entries stream in row by row, top row first,
// entry c of row r for c = 0..r, as signed 16-bit values; num_rows (APB offset 0)
// sets the rows per triangle, 0 is taken as 1 and values above MAX_ROWS as MAX_ROWS.
// After the last entry of a triangle one result transfer carries the largest
// top-to-bottom path sum, saturated to 22 bits signed, and the position counters
// rewind for the next triangle. The block takes one entry per cycle: each entry is
// one read-modify-write of a one-row buffer of best sums (a RAM of MAX_ROWS words),
// read at acceptance and written when the update stage moves on, with the write
// forwarded to a read of the same word. The result is registered after the update
// stage. The only stall is at the result: while a result waits in the output register,
// the next triangle's final entry is held in the update stage until the output drains.
module triangle_max_path_sum_top #(
    parameter int MAX_ROWS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tmps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tmps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // entry stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // [15:0] entry_value
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tmps_pkg::OUT_BYTES_W-1:0]    m_axis_tdata    // [21:0] best_sum, [23:22] 0
);

    import tmps_pkg::*;

    // index and sum widths follow from the row limit
    localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW  = ENTRY_W + 1 + $clog2(MAX_ROWS);
    localparam int XW  = (SW > OUT_W) ? SW : OUT_W;
    localparam int CW0 = $clog2(MAX_ROWS + 1);
    localparam int CW  = (CW0 > NUM_ROWS_W) ? CW0 : NUM_ROWS_W;

    localparam logic signed [XW-1:0] SAT_HI = XW'(OUT_MAX_I);
    localparam logic signed [XW-1:0] SAT_LO = XW'(OUT_MIN_I);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [NUM_ROWS_W-1:0] r_num_rows;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NUM_ROWS_W'(1);
        end else if (cfg_wr && (paddr == REG_NUM_ROWS)) begin
            r_num_rows <= pwdata[NUM_ROWS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            REG_NUM_ROWS: prdata = APB_DATA_W'(r_num_rows);
            default:      prdata = '0;
        endcase
    end

    // effective row count, clamped to 1..MAX_ROWS
    logic [CW-1:0] rows_raw;
    logic [CW-1:0] rows_eff;

    assign rows_raw = CW'(r_num_rows);
    assign rows_eff = (rows_raw == '0) ? CW'(1) :
                      (rows_raw > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : rows_raw;

    // ------------------------------------------------------------------
    // stage 0: position counters, buffer read issued on acceptance
    // ------------------------------------------------------------------
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_col;
    logic [AW-1:0] n_row;
    logic [AW-1:0] n_col;
    logic          s0_accept;
    logic          s0_last_row;
    logic          s0_last_col;
    t_s1_ctl       s0_ctl;

    // stage 1 registers
    logic                      r_s1_valid;
    t_s1_ctl                   r_s1_ctl;
    logic [AW-1:0]             r_s1_addr;
    logic signed [ENTRY_W-1:0] r_s1_value;
    logic                      s1_go;

    // result register
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;

    // the update stage moves on unless it holds a result that cannot be stored
    assign s1_go         = !(r_s1_valid && r_s1_ctl.tri_end && r_out_valid && !m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign s0_accept     = s_axis_tvalid && s_axis_tready;

    assign s0_last_row = (CW'(r_row) + CW'(1)) >= rows_eff;
    assign s0_last_col = (r_col == r_row);

    always_comb begin
        s0_ctl.top_row   = (r_row == '0);
        s0_ctl.first_col = (r_col == '0);
        s0_ctl.last_col  = s0_last_col;
        s0_ctl.last_row  = s0_last_row;
        s0_ctl.tri_end   = s0_last_col && s0_last_row;
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (s0_accept) begin
            if (s0_last_col) begin
                n_col = '0;
                n_row = s0_last_row ? '0 : r_row + AW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // row buffer with write forwarding
    // ------------------------------------------------------------------
    logic                  ram_wr_en;
    logic signed [SW-1:0]  ram_rd_data;
    logic signed [SW-1:0]  fresh;
    logic                  r_fwd_hit;
    logic signed [SW-1:0]  r_fwd_data;
    logic signed [SW-1:0]  above;

    assign ram_wr_en = r_s1_valid && s1_go;

    tmps_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ROWS)
    ) u_row_best (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (fresh),
        .i_rd_en   (s0_accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    // a read at the same edge as a write to that word sees the new value
    always_ff @(posedge i_clk) begin
        if (s0_accept) begin
            r_fwd_hit  <= ram_wr_en && (r_s1_addr == r_col);
            r_fwd_data <= fresh;
        end
    end

    assign above = r_fwd_hit ? r_fwd_data : ram_rd_data;

    // ------------------------------------------------------------------
    // stage 1: best-sum update, running maximum over the last row
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s0_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_accept) begin
            r_s1_ctl   <= s0_ctl;
            r_s1_addr  <= r_col;
            r_s1_value <= s_axis_tdata;
        end
    end

    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_max;
    logic signed [SW-1:0] value_ext;
    logic signed [SW-1:0] best_in;
    logic signed [SW-1:0] n_max;
    logic signed [XW-1:0] max_ext;
    logic signed [XW-1:0] max_sat;

    assign value_ext = SW'(r_s1_value);

    // edges take their only neighbor, the top entry takes its own value
    always_comb begin
        if (r_s1_ctl.top_row) begin
            best_in = '0;
        end else if (r_s1_ctl.first_col) begin
            best_in = above;
        end else if (r_s1_ctl.last_col) begin
            best_in = r_left;
        end else begin
            best_in = (r_left > above) ? r_left : above;
        end
    end

    assign fresh = value_ext + best_in;

    assign n_max = (r_s1_ctl.first_col || (fresh > r_max)) ? fresh : r_max;

    assign max_ext = XW'(n_max);
    assign max_sat = (max_ext > SAT_HI) ? SAT_HI :
                     (max_ext < SAT_LO) ? SAT_LO : max_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_max  <= '0;
        end else if (ram_wr_en) begin
            r_left <= r_s1_ctl.tri_end ? '0 : above;
            if (r_s1_ctl.last_row) begin
                r_max <= n_max;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ram_wr_en && r_s1_ctl.tri_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_wr_en && r_s1_ctl.tri_end) begin
            r_out_data <= max_sat[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_BYTES_W'(r_out_data);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_row)
        else $error("column index beyond row index");

    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_s1_ctl.tri_end && r_out_valid))
        else $error("input stalled without a blocked result");

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_s1_valid && r_s1_ctl.tri_end && s1_go))
        else $error("result raised without a completed triangle");

    a_rewind_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_accept && s0_ctl.tri_end) |=> (r_row == '0 && r_col == '0))
        else $error("counters did not rewind after the final entry");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import tmps_pkg::*;

    localparam int ROWS_MAX       = 64;
    localparam int RANDOM_ENTRIES = 1050;
    localparam int PROBE_ENTRIES  = 136;   // sixteen full rows under an above-limit row count
    localparam int SETTLE_CYCLES  = 8;     // idle clocks once every entry and result is through
    localparam int QUIET_LIMIT    = 500;   // cycles with no transfer on any port

    // value patterns for generated entries
    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_HIGHEST,
        MIX_LOWEST,
        MIX_EXTREMES
    } t_value_mix;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata = '0;   // [15:0] entry_value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;        // [21:0] best_sum, [23:22] zero

    // stimulus and scoreboard
    logic [15:0]            entry_queue[$];
    logic signed [21:0]     pending_sums[$];
    int                     entries_sent = 0;
    int                     entries_taken = 0;
    int                     results_seen = 0;
    int                     rows_writes = 0;
    int                     mismatch_count = 0;
    int                     lowest_sum = 32'h7fffffff;
    int                     highest_sum = -32'h7fffffff;
    bit                     pace_on = 1'b1;
    int                     send_gap = 0;
    int                     recv_stall = 0;
    int                     quiet_cycles = 0;

    // predictor state: one row of best path sums plus the position in the triangle
    logic signed [22:0]     best_row [0:ROWS_MAX-1];
    logic [5:0]             cur_row;
    logic [5:0]             cur_col;
    logic signed [22:0]     left_best;
    logic signed [22:0]     last_row_max;
    logic [NUM_ROWS_W-1:0]  rows_reg;

    triangle_max_path_sum_top #(
        .MAX_ROWS(ROWS_MAX)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // zero counts as one row, anything above the buffer depth as the full depth
    function automatic int rows_in_use();
        if (rows_reg == 0) return 1;
        if (rows_reg > ROWS_MAX) return ROWS_MAX;
        return rows_reg;
    endfunction

    // entries still needed to close the triangle in progress
    function automatic int entries_left();
        int n;
        int k;
        n = cur_row + 1 - cur_col;
        for (k = cur_row + 1; k < rows_in_use(); k++) n += k + 1;
        return n;
    endfunction

    // one entry through the best-sum row; returns 1 when it closes a triangle
    function automatic bit advance_triangle(input logic signed [15:0] entry,
                                            output logic signed [21:0] total);
        logic signed [22:0] above;
        logic signed [22:0] fresh;
        bit                 last;
        above = best_row[cur_col];
        if (cur_row == 0) begin
            fresh = entry;
        end else if (cur_col == 0) begin
            fresh = entry + above;
        end else if (cur_col == cur_row) begin
            fresh = entry + left_best;
        end else begin
            fresh = entry + ((left_best > above) ? left_best : above);
        end
        left_best = above;
        best_row[cur_col] = fresh;
        last = (cur_row + 1 >= rows_in_use());
        if (last) begin
            last_row_max = (cur_col == 0 || fresh > last_row_max) ? fresh : last_row_max;
        end
        total = '0;
        if (cur_col == cur_row) begin
            cur_col = '0;
            if (last) begin
                cur_row = '0;
                left_best = '0;
                if (last_row_max > OUT_MAX_I) begin
                    total = 22'(OUT_MAX_I);
                end else if (last_row_max < OUT_MIN_I) begin
                    total = 22'(OUT_MIN_I);
                end else begin
                    total = last_row_max[21:0];
                end
                return 1'b1;
            end
            cur_row++;
        end else begin
            cur_col++;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] pick_entry(input t_value_mix mix);
        int n;
        case (mix)
            MIX_NARROW: begin
                n = $urandom_range(0, 40) - 20;
                return n[15:0];
            end
            MIX_HIGHEST: return 16'h7fff;
            MIX_LOWEST:  return 16'h8000;
            MIX_EXTREMES: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_value_mix pick_mix();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return MIX_FULL;
            5, 6, 7:       return MIX_NARROW;
            8:             return MIX_EXTREMES;
            default:       return ($urandom_range(0, 1) != 0) ? MIX_HIGHEST : MIX_LOWEST;
        endcase
    endfunction

    task automatic push_entry(input logic [15:0] value);
        entry_queue.push_back(value);
        entries_sent++;
    endtask

    task automatic queue_entries(input int count, input t_value_mix mix);
        repeat (count) push_entry(pick_entry(mix));
    endtask

    // hold the sender until every entry is taken and every result is back
    task automatic settle();
        while (entries_taken != entries_sent || pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write num_rows with junk in the unused bits, then read it back
    task automatic set_rows(input logic [NUM_ROWS_W-1:0] value);
        logic [APB_DATA_W-1:0] junk;
        settle();
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NUM_ROWS;
        pwdata  <= {junk[APB_DATA_W-1:NUM_ROWS_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[NUM_ROWS_W-1:0] !== value) begin
            flag_mismatch($sformatf("num_rows reads %0d, written %0d",
                                    prdata[NUM_ROWS_W-1:0], value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        rows_writes++;
    endtask

    // entry driver: holds an offered transfer until taken, idles in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // transfer still pending, keep it steady
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (entry_queue.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (pace_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 18);
            s_axis_tvalid <= 1'b0;
        end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= entry_queue.pop_front();
        end
    end

    // result sink with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else if (pace_on && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: predicts on every entry transfer, checks every result transfer
    always @(posedge i_clk) begin : monitor
        logic signed [21:0] total;
        logic signed [21:0] want;
        bit                 moved;
        if (!i_rst_n) begin
            foreach (best_row[k]) best_row[k] = '0;
            cur_row = '0;
            cur_col = '0;
            left_best = '0;
            last_row_max = '0;
            rows_reg = 7'd1;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                results_seen++;
                if ($signed(m_axis_tdata[21:0]) < lowest_sum) begin
                    lowest_sum = $signed(m_axis_tdata[21:0]);
                end
                if ($signed(m_axis_tdata[21:0]) > highest_sum) begin
                    highest_sum = $signed(m_axis_tdata[21:0]);
                end
                if (pending_sums.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %0d",
                                            $signed(m_axis_tdata[21:0])));
                end else begin
                    want = pending_sums.pop_front();
                    if (m_axis_tdata[21:0] !== want) begin
                        flag_mismatch($sformatf("best_sum %0d, predicted %0d",
                                                $signed(m_axis_tdata[21:0]), want));
                    end
                    if (m_axis_tdata[OUT_BYTES_W-1:OUT_W] !== '0) begin
                        flag_mismatch("padding bits of the result are not zero");
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                entries_taken++;
                if (advance_triangle(s_axis_tdata, total)) pending_sums.push_back(total);
            end
            if (psel && penable && pready) begin
                moved = 1'b1;
                if (pwrite && paddr == REG_NUM_ROWS) rows_reg = pwdata[NUM_ROWS_W-1:0];
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int               random_start;
        int               full;
        logic [NUM_ROWS_W-1:0] rows_pick;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset row count of one: every entry is a whole triangle
        push_entry(16'h7fff); push_entry(16'h8000); push_entry(16'h0000); push_entry(16'hffff);
        // zero rows behaves as one row
        set_rows(7'd0);
        push_entry(16'h0001); push_entry(16'hfffe);
        // two rows: path goes right, then left
        set_rows(7'd2);
        push_entry(16'h7fff); push_entry(16'h8000); push_entry(16'h7fff);
        push_entry(16'hffff); push_entry(16'h0005); push_entry(16'hfff9);
        // three rows: inner entry picks the better of its two parents
        set_rows(7'd3);
        push_entry(16'h0000);
        push_entry(16'h0064); push_entry(16'hff9c);
        push_entry(16'hffce); push_entry(16'h003c); push_entry(16'hffce);
        // row count cut short mid-row: the current row becomes the last one
        set_rows(7'd4);
        push_entry(16'h0003);
        push_entry(16'h0001); push_entry(16'h0002);
        push_entry(16'hfffb);
        set_rows(7'd2);
        queue_entries(entries_left(), MIX_NARROW);

        // above-limit row count: sixteen rows at the top of the range close nothing,
        // then a single-row count ends the triangle on the next row at the bottom
        pace_on = 1'b0;
        set_rows(7'd127);
        queue_entries(PROBE_ENTRIES, MIX_HIGHEST);
        set_rows(7'd1);
        pace_on = 1'b1;
        queue_entries(entries_left(), MIX_LOWEST);

        // random triangles, mostly small, some cut off partway before a new row count
        random_start = entries_sent;
        while (entries_sent - random_start < RANDOM_ENTRIES) begin
            case ($urandom_range(0, 19))
                0:                          rows_pick = 7'd0;
                1:                          rows_pick = 7'($urandom_range(11, 16));
                2, 3, 4, 5, 6, 7, 8, 9, 10: rows_pick = 7'($urandom_range(1, 5));
                default:                    rows_pick = 7'($urandom_range(6, 10));
            endcase
            set_rows(rows_pick);
            pace_on = (entries_sent - random_start < RANDOM_ENTRIES * 4 / 5)
                      && ($urandom_range(0, 2) != 0);
            queue_entries(entries_left(), pick_mix());
            full = rows_in_use() * (rows_in_use() + 1) / 2;
            repeat ($urandom_range(1, 6)) queue_entries(full, pick_mix());
            if (full > 1 && $urandom_range(0, 3) == 0) begin
                queue_entries($urandom_range(1, full - 1), pick_mix());
            end
        end

        pace_on = 1'b0;
        settle();
        $display("%0d triangles checked from %0d entries over %0d row-count settings",
                 results_seen, entries_taken, rows_writes);
        $display("best sums ranged from %0d to %0d", lowest_sum, highest_sum);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tmps_pkg.sv
hw/rtl/tmps_ram.sv
hw/rtl/triangle_max_path_sum_top.sv
test/testbench.sv
